@@ hw/rtl/frl_pkg.sv @@
// ----------------------------------------------------------------------------
// frl_pkg
// Shared widths, reset values and controller/datapath handshake types for the
// frequency-ranked recent list.
// ----------------------------------------------------------------------------
package frl_pkg;

  // Port field widths
  localparam int unsigned IN_ID_W   = 16;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned OUT_ID_W  = 16;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned CAP_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;     // capture the new identifier, restart the scan
    logic search;    // scan entries for the identifier
    logic shift_rd;  // read the entry above the shift pointer
    logic shift_wr;  // write it one place down, step the pointer
    logic place;     // write the hit or missed entry, update occupancy
    logic read;      // stream the list to the output register
  } frl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_end;    // no read pending and no address left to issue
    logic match_now;   // entry under compare carries the identifier
    logic hit;         // identifier was found in this transaction
    logic same_pos;    // hit entry stays where it is
    logic shift_last;  // next shift write is the final one
  } frl_status_t;

endpackage

@@ hw/rtl/frl_if.sv @@
// ----------------------------------------------------------------------------
// frl_in_if / frl_out_if
// Valid/ready channels for identifier input and list readout.
// ----------------------------------------------------------------------------
interface frl_in_if import frl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IN_ID_W-1:0] color_id;

  modport source (output valid, output color_id, input ready);
  modport sink   (input valid, input color_id, output ready);
endinterface

interface frl_out_if import frl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RANK_W-1:0]    rank;
  logic [OUT_ID_W-1:0]  entry_id;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 was_present;
  logic                 did_evict;
  logic                 last_entry;

  modport source (output valid, output rank, output entry_id, output entry_count,
                  output was_present, output did_evict, output last_entry,
                  input ready);
  modport sink   (input valid, input rank, input entry_id, input entry_count,
                  input was_present, input did_evict, input last_entry,
                  output ready);
endinterface

@@ hw/rtl/frl_ctrl.sv @@
// ----------------------------------------------------------------------------
// frl_ctrl
// Sequencer: search, reorder, place and readout of one transaction.
// ----------------------------------------------------------------------------
module frl_ctrl import frl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  frl_status_t status,
  output frl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEARCH   = 3'd1;
  localparam logic [2:0] ST_DECIDE   = 3'd2;
  localparam logic [2:0] ST_SHIFT_RD = 3'd3;
  localparam logic [2:0] ST_SHIFT_WR = 3'd4;
  localparam logic [2:0] ST_PLACE    = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.match_now || status.scan_end) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.hit && !status.same_pos) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = status.shift_last ? ST_PLACE : ST_SHIFT_RD;
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (status.scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/frl_datapath.sv @@
// ----------------------------------------------------------------------------
// frl_datapath
// Entry memory, scan pointers, placement logic and the output register.
// ----------------------------------------------------------------------------
module frl_datapath import frl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_data,
  input  logic [IN_ID_W-1:0] in_color_id,
  input  frl_cmd_t           cmd,
  output frl_status_t        status,
  frl_out_if.source          out_ch
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [IDX_W-1:0]      IDX_ONE   = IDX_W'(1);
  localparam logic [OCC_W-1:0]      OCC_ONE   = OCC_W'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Entry memory
  logic [ID_BITS-1:0]    mem_id  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] mem_cnt [MAX_ENTRIES];

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ID_BITS-1:0]    rd_id_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ID_BITS-1:0]    wr_id;
  logic [COUNT_BITS-1:0] wr_cnt;

  // Control and working registers
  logic [CAP_W-1:0]      cap_r;
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      addr_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  valid_r;
  logic [ID_BITS-1:0]    id_r;
  logic                  hit_r;
  logic                  evict_r;
  logic [IDX_W-1:0]      sh_r;
  logic [IDX_W-1:0]      q_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [IDX_W-1:0]      run_start_r;
  logic [COUNT_BITS-1:0] prev_cnt_r;

  // Output register
  logic                 out_valid_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic [OUT_ID_W-1:0]  out_id_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic                 out_present_r;
  logic                 out_evict_r;
  logic                 out_last_r;

  logic                  more;
  logic                  match;
  logic                  out_free;
  logic                  move;
  logic                  valid_nxt;
  logic                  full;
  logic [31:0]           cap32;
  logic [31:0]           eff32;
  logic [31:0]           occ32;
  logic [OCC_W-1:0]      occ_dec;
  logic [OCC_W-1:0]      miss_pos;
  logic [63:0]           id_wide;
  logic [63:0]           out_id_wide;
  logic [63:0]           out_cnt_wide;
  logic [31:0]           rank_wide;
  logic [IDX_W-1:0]      last_idx;
  logic                  new_run;
  logic                  sat;

  assign more     = addr_r < occ_r;
  assign match    = rd_id_r == id_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign move     = cmd.read && valid_r && out_free;
  assign sat      = rd_cnt_r == COUNT_MAX;
  assign new_run  = (idx_r == '0) || (rd_cnt_r != prev_cnt_r);

  // Capacity clamps to 1..MAX_ENTRIES
  always_comb begin
    cap32 = 32'(cap_r);
    occ32 = 32'(occ_r);
    if (cap32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (cap32 > MAX_ENTRIES) begin
      eff32 = 32'(MAX_ENTRIES);
    end else begin
      eff32 = cap32;
    end
    full     = occ32 >= eff32;
    occ_dec  = occ_r - OCC_ONE;
    miss_pos = full ? occ_dec : occ_r;
  end

  always_comb begin
    id_wide      = 64'(in_color_id);
    out_id_wide  = 64'(rd_id_r);
    out_cnt_wide = 64'(rd_cnt_r);
    rank_wide    = 32'(idx_r);
    last_idx     = occ_dec[IDX_W-1:0];
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_r[IDX_W-1:0];
    if (cmd.search) begin
      rd_en = more;
    end else if (cmd.read) begin
      rd_en = more && (!valid_r || move);
    end else if (cmd.shift_rd) begin
      rd_en   = 1'b1;
      rd_addr = sh_r - IDX_ONE;
    end

    wr_en   = 1'b0;
    wr_addr = sh_r;
    wr_id   = rd_id_r;
    wr_cnt  = rd_cnt_r;
    if (cmd.shift_wr) begin
      wr_en = 1'b1;
    end else if (cmd.place) begin
      wr_en = 1'b1;
      wr_id = id_r;
      if (hit_r) begin
        wr_addr = q_r;
        wr_cnt  = cnt_r;
      end else begin
        wr_addr = miss_pos[IDX_W-1:0];
        wr_cnt  = COUNT_ONE;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.start || cmd.place) begin
      valid_nxt = 1'b0;
    end else if (cmd.search) begin
      valid_nxt = rd_en;
    end else if (cmd.read) begin
      valid_nxt = rd_en || (valid_r && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]  <= wr_id;
      mem_cnt[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_id_r  <= mem_id[rd_addr];
      rd_cnt_r <= mem_cnt[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.place && !hit_r && !full) begin
        occ_r <= occ_r + OCC_ONE;
      end
      valid_r <= valid_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r    <= id_wide[ID_BITS-1:0];
      hit_r   <= 1'b0;
      evict_r <= 1'b0;
    end
    if (cmd.start || cmd.place) begin
      addr_r <= '0;
    end else if (rd_en && !cmd.shift_rd) begin
      addr_r <= addr_r + OCC_ONE;
      idx_r  <= addr_r[IDX_W-1:0];
    end
    if (cmd.search && valid_r) begin
      prev_cnt_r <= rd_cnt_r;
      if (new_run) begin
        run_start_r <= idx_r;
      end
      if (match) begin
        hit_r <= 1'b1;
        sh_r  <= idx_r;
        cnt_r <= sat ? rd_cnt_r : rd_cnt_r + COUNT_ONE;
        // The list stays sorted, so the entry moves to the head of its run of
        // equal counts; a saturated count stays put.
        q_r   <= (sat || new_run) ? idx_r : run_start_r;
      end
    end
    if (cmd.shift_wr) begin
      sh_r <= sh_r - IDX_ONE;
    end
    if (cmd.place && !hit_r) begin
      evict_r <= full;
    end
    if (move) begin
      out_rank_r    <= rank_wide[RANK_W-1:0];
      out_id_r      <= out_id_wide[OUT_ID_W-1:0];
      out_cnt_r     <= out_cnt_wide[OUT_CNT_W-1:0];
      out_present_r <= hit_r;
      out_evict_r   <= evict_r;
      out_last_r    <= idx_r == last_idx;
    end
  end

  always_comb begin
    status.scan_end   = !valid_r && !more;
    status.match_now  = valid_r && match;
    status.hit        = hit_r;
    status.same_pos   = sh_r == q_r;
    status.shift_last = sh_r == (q_r + IDX_ONE);
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.entry_id    = out_id_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.was_present = out_present_r;
  assign out_ch.did_evict   = out_evict_r;
  assign out_ch.last_entry  = out_last_r;

endmodule

@@ hw/rtl/frequency_ranked_recent_list_core.sv @@
// ----------------------------------------------------------------------------
// frequency_ranked_recent_list_core
// List of recently used identifiers kept in order of descending use count.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one identifier per transaction (valid/ready, accepted when both
//            are high). Taken only while the block is between transactions.
//   out_ch : after each identifier the whole list streams out, rank 0 first,
//            one transaction per entry, last_entry marking the final one.
//   cfg_we/cfg_data : capacity write, taken at any edge with cfg_we high;
//            write it only while the block is idle.
// Each identifier steps through search, decide, reorder (one read and one
// write per moved entry), place and readout. The single read and single
// write port of the entry memory set the pace: it is scanned once to
// search, once per moved entry to reorder, and once to read out. The
// readout itself moves one entry per cycle while the receiver keeps ready
// high.
// Reset clears the occupancy (empty list), restores capacity 8 and empties
// the output register; entry storage is not cleared.
// A stalled receiver holds the output register; the readout waits and
// resumes without losing or repeating entries. A new identifier may be
// accepted while the final entry of the previous list still waits.
// ----------------------------------------------------------------------------
module frequency_ranked_recent_list_core import frl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  frl_in_if.sink           in_ch,
  frl_out_if.source        out_ch
);

  frl_cmd_t    cmd;
  frl_status_t status;
  logic        ctl_in_ready;

  // Sequencer: owns the input handshake and steps through each transaction
  frl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = ctl_in_ready;

  // Storage, scan, reorder and output register
  frl_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_BITS     (ID_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_color_id (in_ch.color_id),
    .cmd         (cmd),
    .status      (status),
    .out_ch      (out_ch)
  );

endmodule
